@@ hdl/ant_pkg.sv @@
`timescale 1ns / 1ps

package ant_pkg;

   localparam int MAX_NOTES_DEF = 16;
   localparam int CNT_W = 5;

   typedef enum logic [2:0] {
      OP_NOTE_ON   = 3'd0,
      OP_NOTE_OFF  = 3'd1,
      OP_REL_CLIP  = 3'd2,
      OP_REL_DEST  = 3'd3,
      OP_ALL_OFF   = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      KIND_DONE  = 3'd0,
      KIND_OFF   = 3'd1,
      KIND_RESET = 3'd2,
      KIND_PASS  = 3'd3,
      KIND_DROP  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      ADDR_I    = 2'd0,
      ADDR_J    = 2'd1,
      ADDR_LAST = 2'd2
   } addr_sel_type;

   typedef enum logic [2:0] {
      FIN_KEEP = 3'd0,
      FIN_HELD = 3'd1,
      FIN_INC  = 3'd2,
      FIN_DEC  = 3'd3,
      FIN_SUB  = 3'd4,
      FIN_ZERO = 3'd5
   } fin_type;

   // One table entry: key is {group, chan, note, clip flag}.
   typedef struct packed {
      logic [15:0] key;
      logic [31:0] dest;
      logic [31:0] source;
      logic [31:0] clip;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic         req_load;
      logic         i_clr;
      logic         i_inc;
      logic         i_from_fb;
      logic         j_clr;
      logic         j_inc;
      logic         cnt_inc;
      logic         fb_set;
      logic         cur_load;
      addr_sel_type addr_sel;
      logic         wr_en;
      logic         wr_from_req;
      logic         held_inc;
      logic         held_dec;
      logic         held_clr;
      logic         drop_inc;
      fin_type      fin;
      logic         emit;
      logic         emit_rd;
      kind_type     kind;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   i_end;
      logic   j_eq_i;
      logic   full;
      logic   exact;
      logic   partial;
      logic   have_fb;
      logic   rel_match;
      logic   rd_dest_eq;
      logic   seen;
      logic   out_free;
   } sts_type;

endpackage

@@ hdl/ant_ram.sv @@
`timescale 1ns / 1ps

module ant_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

@@ hdl/ant_ctrl.sv @@
`timescale 1ns / 1ps

module ant_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ant_pkg::sts_type sts,
   output ant_pkg::cmd_type cmd
);

   import ant_pkg::*;

   typedef enum logic [20:0] {
      S_IDLE     = 21'h000001,
      S_DISPATCH = 21'h000002,
      S_ON       = 21'h000004,
      S_DONE     = 21'h000008,
      S_AO_RD    = 21'h000010,
      S_AO_EV    = 21'h000020,
      S_RS_RD    = 21'h000040,
      S_RS_EV    = 21'h000080,
      S_RSJ_RD   = 21'h000100,
      S_RSJ_EV   = 21'h000200,
      S_RS_EMIT  = 21'h000400,
      S_CNT_RD   = 21'h000800,
      S_CNT_EV   = 21'h001000,
      S_RM_RD    = 21'h002000,
      S_RM_EV    = 21'h004000,
      S_RM_EMIT  = 21'h008000,
      S_MV_RD    = 21'h010000,
      S_MV_WR    = 21'h020000,
      S_OFF_RD   = 21'h040000,
      S_OFF_EV   = 21'h080000,
      S_OFF_EMIT = 21'h100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            cmd.i_clr = 1'b1;
            unique case (sts.op)
               OP_NOTE_ON:  state_in = S_ON;
               OP_NOTE_OFF: state_in = S_OFF_RD;
               OP_REL_CLIP,
               OP_REL_DEST: state_in = S_CNT_RD;
               OP_ALL_OFF: begin
                  cmd.fin  = FIN_ZERO;
                  state_in = S_AO_RD;
               end
               default: begin
                  cmd.fin  = FIN_HELD;
                  state_in = S_DONE;
               end
            endcase
         end
         S_ON: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.full) begin
                  cmd.drop_inc = 1'b1;
                  cmd.fin      = FIN_HELD;
                  cmd.kind     = KIND_DROP;
               end else begin
                  cmd.wr_en       = 1'b1;
                  cmd.wr_from_req = 1'b1;
                  cmd.held_inc    = 1'b1;
                  cmd.fin         = FIN_INC;
                  cmd.kind        = KIND_PASS;
               end
               state_in = S_IDLE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.kind     = KIND_DONE;
               cmd.held_clr = (sts.op == OP_ALL_OFF);
               state_in     = S_IDLE;
            end
         end
         S_AO_RD: begin
            if (sts.i_end) begin
               cmd.i_clr = 1'b1;
               state_in  = S_RS_RD;
            end else begin
               state_in = S_AO_EV;
            end
         end
         S_AO_EV: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.emit_rd = 1'b1;
               cmd.kind    = KIND_OFF;
               cmd.i_inc   = 1'b1;
               state_in    = S_AO_RD;
            end
         end
         S_RS_RD: begin
            if (sts.i_end) begin
               if (sts.op == OP_ALL_OFF) begin
                  state_in = S_DONE;
               end else begin
                  cmd.i_clr = 1'b1;
                  state_in  = S_RM_RD;
               end
            end else begin
               state_in = S_RS_EV;
            end
         end
         S_RS_EV: begin
            cmd.cur_load = 1'b1;
            if (sts.op == OP_REL_DEST && !sts.rd_dest_eq) begin
               cmd.i_inc = 1'b1;
               state_in  = S_RS_RD;
            end else begin
               cmd.j_clr = 1'b1;
               state_in  = S_RSJ_RD;
            end
         end
         S_RSJ_RD: begin
            cmd.addr_sel = ADDR_J;
            state_in     = sts.j_eq_i ? S_RS_EMIT : S_RSJ_EV;
         end
         S_RSJ_EV: begin
            if (sts.seen) begin
               cmd.i_inc = 1'b1;
               state_in  = S_RS_RD;
            end else begin
               cmd.j_inc = 1'b1;
               state_in  = S_RSJ_RD;
            end
         end
         S_RS_EMIT: begin
            if (sts.out_free) begin
               cmd.emit  = 1'b1;
               cmd.kind  = KIND_RESET;
               cmd.i_inc = 1'b1;
               state_in  = S_RS_RD;
            end
         end
         S_CNT_RD: begin
            if (sts.i_end) begin
               cmd.fin   = FIN_SUB;
               cmd.i_clr = 1'b1;
               state_in  = (sts.op == OP_REL_DEST) ? S_RS_RD : S_RM_RD;
            end else begin
               state_in = S_CNT_EV;
            end
         end
         S_CNT_EV: begin
            cmd.cnt_inc = sts.rel_match;
            cmd.i_inc   = 1'b1;
            state_in    = S_CNT_RD;
         end
         S_RM_RD: begin
            state_in = sts.i_end ? S_DONE : S_RM_EV;
         end
         S_RM_EV: begin
            if (sts.rel_match) begin
               cmd.cur_load = 1'b1;
               state_in     = S_RM_EMIT;
            end else begin
               cmd.i_inc = 1'b1;
               state_in  = S_RM_RD;
            end
         end
         S_RM_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_OFF;
               state_in = S_MV_RD;
            end
         end
         S_MV_RD: begin
            cmd.addr_sel = ADDR_LAST;
            state_in     = S_MV_WR;
         end
         S_MV_WR: begin
            cmd.wr_en    = 1'b1;
            cmd.held_dec = 1'b1;
            state_in     = (sts.op == OP_NOTE_OFF) ? S_OFF_EMIT : S_RM_RD;
         end
         S_OFF_RD: begin
            if (sts.i_end) begin
               if (sts.have_fb) begin
                  cmd.i_from_fb = 1'b1;
                  cmd.fin       = FIN_DEC;
                  state_in      = S_MV_RD;
               end else begin
                  cmd.fin  = FIN_HELD;
                  state_in = S_OFF_EMIT;
               end
            end else begin
               state_in = S_OFF_EV;
            end
         end
         S_OFF_EV: begin
            if (sts.exact) begin
               cmd.fin  = FIN_DEC;
               state_in = S_MV_RD;
            end else begin
               cmd.fb_set = sts.partial && !sts.have_fb;
               cmd.i_inc  = 1'b1;
               state_in   = S_OFF_RD;
            end
         end
         S_OFF_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = KIND_PASS;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/ant_dpath.sv @@
`timescale 1ns / 1ps

module ant_dpath #(
   parameter int MAX_NOTES = ant_pkg::MAX_NOTES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ant_pkg::cmd_type cmd,
   output ant_pkg::sts_type sts,
   input  logic [2:0]       req_op,
   input  logic [3:0]       req_group,
   input  logic [3:0]       req_chan,
   input  logic [6:0]       req_note_number,
   input  logic [31:0]      req_dest,
   input  logic [31:0]      req_source_track,
   input  logic             req_is_from_clip,
   input  logic [31:0]      req_clip,
   input  logic [47:0]      req_frame,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_kind,
   output logic [31:0]      rsp_out_dest,
   output logic [3:0]       rsp_out_group,
   output logic [3:0]       rsp_out_chan,
   output logic [6:0]       rsp_out_note,
   output logic [31:0]      rsp_out_source_track,
   output logic [47:0]      rsp_out_frame,
   output logic [4:0]       rsp_notes_held,
   output logic [15:0]      rsp_overflow_total,
   output logic             rsp_last
);

   import ant_pkg::*;

   localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;

   // Latched request.
   logic [2:0]  op_ff;
   entry_type   req_ent_ff;
   logic [47:0] frame_ff;

   logic [CNT_W-1:0] i_ff, j_ff, cnt_ff, fb_ff, held_ff, fin_ff;
   logic [CNT_W-1:0] fin_in;
   logic             have_fb_ff;
   logic [15:0]      drop_ff, drop_in;
   entry_type        cur_ff;

   logic [ENTRY_W-1:0] rd_raw, wr_data;
   entry_type          rd_ent, emit_ent;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic [CNT_W-1:0]   last_idx;

   assign rd_ent   = entry_type'(rd_raw);
   assign last_idx = held_ff - CNT_W'(1);

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_J:    rd_addr = j_ff[AW-1:0];
         ADDR_LAST: rd_addr = last_idx[AW-1:0];
         default:   rd_addr = i_ff[AW-1:0];
      endcase
   end

   assign wr_addr = cmd.wr_from_req ? held_ff[AW-1:0] : i_ff[AW-1:0];
   assign wr_data = cmd.wr_from_req ? ENTRY_W'(req_ent_ff) : rd_raw;

   ant_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(MAX_NOTES)
   ) u_ram (
      .clock  (clock),
      .wr_en  (cmd.wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_raw)
   );

   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         op_ff      <= req_op;
         req_ent_ff <= '{key:    {req_group, req_chan, req_note_number, req_is_from_clip},
                         dest:   req_dest,
                         source: req_source_track,
                         clip:   req_clip};
         frame_ff   <= req_frame;
      end
      if (cmd.cur_load) begin
         cur_ff <= rd_ent;
      end
   end

   always_comb begin
      unique case (cmd.fin)
         FIN_HELD: fin_in = held_ff;
         FIN_INC:  fin_in = held_ff + CNT_W'(1);
         FIN_DEC:  fin_in = held_ff - CNT_W'(1);
         FIN_SUB:  fin_in = held_ff - cnt_ff;
         FIN_ZERO: fin_in = '0;
         default:  fin_in = fin_ff;
      endcase
   end

   assign drop_in = (cmd.drop_inc && drop_ff != 16'hFFFF) ? drop_ff + 16'd1 : drop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff       <= '0;
         j_ff       <= '0;
         cnt_ff     <= '0;
         fb_ff      <= '0;
         have_fb_ff <= 1'b0;
         held_ff    <= '0;
         fin_ff     <= '0;
         drop_ff    <= '0;
      end else begin
         if (cmd.req_load) begin
            cnt_ff     <= '0;
            have_fb_ff <= 1'b0;
         end
         if (cmd.i_clr) begin
            i_ff <= '0;
         end else if (cmd.i_from_fb) begin
            i_ff <= fb_ff;
         end else if (cmd.i_inc) begin
            i_ff <= i_ff + CNT_W'(1);
         end
         if (cmd.j_clr) begin
            j_ff <= '0;
         end else if (cmd.j_inc) begin
            j_ff <= j_ff + CNT_W'(1);
         end
         if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if (cmd.fb_set) begin
            fb_ff      <= i_ff;
            have_fb_ff <= 1'b1;
         end
         if (cmd.held_clr) begin
            held_ff <= '0;
         end else if (cmd.held_inc) begin
            held_ff <= held_ff + CNT_W'(1);
         end else if (cmd.held_dec) begin
            held_ff <= held_ff - CNT_W'(1);
         end
         fin_ff  <= fin_in;
         drop_ff <= drop_in;
      end
   end

   // Status towards the controller.
   always_comb begin
      sts.op         = op_type'(op_ff);
      sts.i_end      = (i_ff >= held_ff);
      sts.j_eq_i     = (j_ff == i_ff);
      sts.full       = (held_ff >= CNT_W'(MAX_NOTES));
      sts.partial    = (rd_ent.key[15:1] == req_ent_ff.key[15:1]) &&
                       (rd_ent.dest == req_ent_ff.dest);
      sts.exact      = sts.partial && (rd_ent.key[0] == req_ent_ff.key[0]) &&
                       (rd_ent.source == req_ent_ff.source) &&
                       (rd_ent.clip == req_ent_ff.clip);
      sts.have_fb    = have_fb_ff;
      sts.rd_dest_eq = (rd_ent.dest == req_ent_ff.dest);
      sts.rel_match  = (op_ff == OP_REL_DEST) ? sts.rd_dest_eq
                       : (rd_ent.key[0] && rd_ent.clip == req_ent_ff.clip);
      sts.seen       = (rd_ent.dest == cur_ff.dest) &&
                       (rd_ent.key[15:8] == cur_ff.key[15:8]);
      sts.out_free   = !rsp_valid || rsp_ready;
   end

   // Output register.
   assign emit_ent = cmd.emit_rd ? rd_ent : cur_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_kind           <= cmd.kind;
         rsp_notes_held     <= fin_in;
         rsp_overflow_total <= drop_in;
         unique case (cmd.kind)
            KIND_PASS, KIND_DROP: begin
               rsp_out_dest         <= req_ent_ff.dest;
               rsp_out_group        <= req_ent_ff.key[15:12];
               rsp_out_chan         <= req_ent_ff.key[11:8];
               rsp_out_note         <= req_ent_ff.key[7:1];
               rsp_out_source_track <= req_ent_ff.source;
               rsp_out_frame        <= frame_ff;
               rsp_last             <= 1'b1;
            end
            KIND_OFF: begin
               rsp_out_dest         <= emit_ent.dest;
               rsp_out_group        <= emit_ent.key[15:12];
               rsp_out_chan         <= emit_ent.key[11:8];
               rsp_out_note         <= emit_ent.key[7:1];
               rsp_out_source_track <= emit_ent.source;
               rsp_out_frame        <= frame_ff;
               rsp_last             <= 1'b0;
            end
            KIND_RESET: begin
               rsp_out_dest         <= cur_ff.dest;
               rsp_out_group        <= cur_ff.key[15:12];
               rsp_out_chan         <= cur_ff.key[11:8];
               rsp_out_note         <= '0;
               rsp_out_source_track <= '0;
               rsp_out_frame        <= frame_ff;
               rsp_last             <= 1'b0;
            end
            default: begin
               rsp_out_dest         <= '0;
               rsp_out_group        <= '0;
               rsp_out_chan         <= '0;
               rsp_out_note         <= '0;
               rsp_out_source_track <= '0;
               rsp_out_frame        <= '0;
               rsp_last             <= 1'b1;
            end
         endcase
      end
   end

endmodule

@@ hdl/active_note_tracker.sv @@
`timescale 1ns / 1ps

// Table of sounding MIDI notes with hung-note release.
// A request arrives on the req_ channel (valid/ready) and carries an operation:
// note-on, note-off, clip release, destination release or all-off. Each
// request produces one or more results on the rsp_ channel; the final one of
// a request has rsp_last set, and every result of a request reports the
// table occupancy and the dropped note-on count as they stand once the whole
// request has been applied.
// One request is handled at a time: the table lives in a RAM with registered
// read, and every scan step is split into an address step and a compare
// step. All-off and destination release add a channel-reset scan with an
// inner dedupe compare.
// A new request is taken once the previous one has put its last result into
// the output register, even if that result has not yet been collected.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; nothing is lost. Reset empties the table and clears the
// overflow count; no clearing pass is needed.

module active_note_tracker #(
   parameter int MAX_NOTES = ant_pkg::MAX_NOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_group,
   input  logic [3:0]  req_chan,
   input  logic [6:0]  req_note_number,
   input  logic [31:0] req_dest,
   input  logic [31:0] req_source_track,
   input  logic        req_is_from_clip,
   input  logic [31:0] req_clip,
   input  logic [47:0] req_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_kind,
   output logic [31:0] rsp_out_dest,
   output logic [3:0]  rsp_out_group,
   output logic [3:0]  rsp_out_chan,
   output logic [6:0]  rsp_out_note,
   output logic [31:0] rsp_out_source_track,
   output logic [47:0] rsp_out_frame,
   output logic [4:0]  rsp_notes_held,
   output logic [15:0] rsp_overflow_total,
   output logic        rsp_last
);

   import ant_pkg::*;

   // Commands from the sequencer and status back from the datapath.
   cmd_type cmd;
   sts_type sts;

   // The sequencer owns all ordering: the counting pass that fixes the final
   // occupancy, the dedupe scan for channel resets and the swap-remove moves.
   ant_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .sts      (sts),
      .cmd      (cmd)
   );

   // The datapath holds the table RAM, the scan indexes, the counters and the
   // output register.
   ant_dpath #(
      .MAX_NOTES(MAX_NOTES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_op              (req_op),
      .req_group           (req_group),
      .req_chan            (req_chan),
      .req_note_number     (req_note_number),
      .req_dest            (req_dest),
      .req_source_track    (req_source_track),
      .req_is_from_clip    (req_is_from_clip),
      .req_clip            (req_clip),
      .req_frame           (req_frame),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_kind            (rsp_kind),
      .rsp_out_dest        (rsp_out_dest),
      .rsp_out_group       (rsp_out_group),
      .rsp_out_chan        (rsp_out_chan),
      .rsp_out_note        (rsp_out_note),
      .rsp_out_source_track(rsp_out_source_track),
      .rsp_out_frame       (rsp_out_frame),
      .rsp_notes_held      (rsp_notes_held),
      .rsp_overflow_total  (rsp_overflow_total),
      .rsp_last            (rsp_last)
   );

endmodule

@@ hdl/ant_check.sv @@
`timescale 1ns / 1ps

module ant_check #(
   parameter int MAX_NOTES = ant_pkg::MAX_NOTES_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_kind,
   input logic [4:0]  rsp_notes_held,
   input logic        rsp_last
);

   import ant_pkg::*;

   // A result waiting for the receiver keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) && $stable(rsp_last))
      else $error("stalled result changed");

   // Only one request is in work at a time.
   a_one_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // Occupancy never exceeds the table size.
   a_held_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_notes_held <= 5'(MAX_NOTES))
      else $error("occupancy beyond table size");

   // Echo, drop and done results close a request; note-offs and resets never do.
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == KIND_DONE || rsp_kind == KIND_PASS ||
                                  rsp_kind == KIND_DROP)))
      else $error("last flag does not match result kind");

endmodule

bind active_note_tracker ant_check #(.MAX_NOTES(MAX_NOTES)) u_check (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_kind      (rsp_kind),
   .rsp_notes_held(rsp_notes_held),
   .rsp_last      (rsp_last)
);

@@ tb/active_note_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the note tracker, predicts the results of every
// accepted request and compares them with what comes out.
module active_note_checker #(
   parameter int MAX_NOTES = ant_pkg::MAX_NOTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_op,
   input  logic [3:0]  req_group,
   input  logic [3:0]  req_chan,
   input  logic [6:0]  req_note_number,
   input  logic [31:0] req_dest,
   input  logic [31:0] req_source_track,
   input  logic        req_is_from_clip,
   input  logic [31:0] req_clip,
   input  logic [47:0] req_frame,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [2:0]  rsp_kind,
   input  logic [31:0] rsp_out_dest,
   input  logic [3:0]  rsp_out_group,
   input  logic [3:0]  rsp_out_chan,
   input  logic [6:0]  rsp_out_note,
   input  logic [31:0] rsp_out_source_track,
   input  logic [47:0] rsp_out_frame,
   input  logic [4:0]  rsp_notes_held,
   input  logic [15:0] rsp_overflow_total,
   input  logic        rsp_last,
   output int          fail_count,
   output int          pending
);

   import ant_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [31:0] dest;
      logic [3:0]  group;
      logic [3:0]  chan;
      logic [6:0]  note;
      logic [31:0] source;
      logic [47:0] frame;
      logic [4:0]  held;
      logic [15:0] dropped;
      logic        last;
   } note_msg_type;

   logic [3:0]  held_group[MAX_NOTES];
   logic [3:0]  held_chan[MAX_NOTES];
   logic [6:0]  held_note[MAX_NOTES];
   logic        held_clip_flag[MAX_NOTES];
   logic [31:0] held_dest[MAX_NOTES];
   logic [31:0] held_source[MAX_NOTES];
   logic [31:0] held_clip[MAX_NOTES];
   int          notes_held;
   int          drop_total;

   note_msg_type step_msgs[$];
   note_msg_type awaited_msgs[$];

   assign pending = awaited_msgs.size();

   function automatic void push_msg(kind_type k, logic [31:0] d, logic [3:0] g,
                                    logic [3:0] c, logic [6:0] n, logic [31:0] s,
                                    logic [47:0] f);
      note_msg_type m;
      m.kind = k;
      m.dest = d;
      m.group = g;
      m.chan = c;
      m.note = n;
      m.source = s;
      m.frame = f;
      m.held = '0;
      m.dropped = '0;
      m.last = 1'b0;
      step_msgs.push_back(m);
   endfunction

   // Swap-remove: the last entry moves into the freed slot.
   function automatic void drop_entry(int i);
      int t;
      t = notes_held - 1;
      held_group[i] = held_group[t];
      held_chan[i] = held_chan[t];
      held_note[i] = held_note[t];
      held_clip_flag[i] = held_clip_flag[t];
      held_dest[i] = held_dest[t];
      held_source[i] = held_source[t];
      held_clip[i] = held_clip[t];
      notes_held = t;
   endfunction

   function automatic void push_channel_resets(bit only_dest, logic [31:0] d,
                                               logic [47:0] f);
      bit seen;
      for (int i = 0; i < notes_held; i++) begin
         if (only_dest && held_dest[i] != d) continue;
         seen = 1'b0;
         for (int j = 0; j < i; j++) begin
            if (held_dest[j] == held_dest[i] && held_group[j] == held_group[i] &&
                held_chan[j] == held_chan[i]) seen = 1'b1;
         end
         if (!seen) push_msg(KIND_RESET, held_dest[i], held_group[i], held_chan[i],
                             '0, '0, f);
      end
   endfunction

   function automatic void apply_request(logic [2:0] op, logic [3:0] g, logic [3:0] c,
                                         logic [6:0] n, logic [31:0] d, logic [31:0] s,
                                         logic fc, logic [31:0] cl, logic [47:0] f);
      int fallback;
      bit exact;
      int i;
      note_msg_type m;
      fallback = -1;
      exact = 1'b0;
      step_msgs.delete();
      case (op)
         OP_NOTE_ON: begin
            if (notes_held >= MAX_NOTES) begin
               if (drop_total < 65535) drop_total++;
               push_msg(KIND_DROP, d, g, c, n, s, f);
            end else begin
               held_group[notes_held] = g;
               held_chan[notes_held] = c;
               held_note[notes_held] = n;
               held_clip_flag[notes_held] = fc;
               held_dest[notes_held] = d;
               held_source[notes_held] = s;
               held_clip[notes_held] = cl;
               notes_held++;
               push_msg(KIND_PASS, d, g, c, n, s, f);
            end
         end
         OP_NOTE_OFF: begin
            for (i = 0; i < notes_held && !exact; i++) begin
               if (held_group[i] == g && held_chan[i] == c && held_note[i] == n &&
                   held_dest[i] == d) begin
                  if (held_source[i] == s && held_clip_flag[i] == fc &&
                      held_clip[i] == cl) begin
                     drop_entry(i);
                     exact = 1'b1;
                  end else if (fallback < 0) fallback = i;
               end
            end
            if (!exact && fallback >= 0) drop_entry(fallback);
            push_msg(KIND_PASS, d, g, c, n, s, f);
         end
         OP_REL_CLIP: begin
            i = 0;
            while (i < notes_held) begin
               if (!held_clip_flag[i] || held_clip[i] != cl) i++;
               else begin
                  push_msg(KIND_OFF, held_dest[i], held_group[i], held_chan[i],
                           held_note[i], held_source[i], f);
                  drop_entry(i);
               end
            end
            push_msg(KIND_DONE, '0, '0, '0, '0, '0, '0);
         end
         OP_REL_DEST: begin
            push_channel_resets(1'b1, d, f);
            i = 0;
            while (i < notes_held) begin
               if (held_dest[i] != d) i++;
               else begin
                  push_msg(KIND_OFF, d, held_group[i], held_chan[i], held_note[i],
                           held_source[i], f);
                  drop_entry(i);
               end
            end
            push_msg(KIND_DONE, '0, '0, '0, '0, '0, '0);
         end
         OP_ALL_OFF: begin
            for (i = 0; i < notes_held; i++)
               push_msg(KIND_OFF, held_dest[i], held_group[i], held_chan[i],
                        held_note[i], held_source[i], f);
            push_channel_resets(1'b0, '0, f);
            notes_held = 0;
            push_msg(KIND_DONE, '0, '0, '0, '0, '0, '0);
         end
         default: push_msg(KIND_DONE, '0, '0, '0, '0, '0, '0);
      endcase
      foreach (step_msgs[k]) begin
         m = step_msgs[k];
         m.held = notes_held[4:0];
         m.dropped = drop_total[15:0];
         m.last = (k == step_msgs.size() - 1);
         awaited_msgs.push_back(m);
      end
   endfunction

   always @(posedge clock) begin
      note_msg_type m;
      if (reset) begin
         notes_held = 0;
         drop_total = 0;
         fail_count = 0;
         awaited_msgs.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_msgs.size() == 0) begin
               $error("result with no request outstanding, kind %0d", rsp_kind);
               fail_count++;
            end else begin
               m = awaited_msgs.pop_front();
               if (rsp_kind != m.kind) begin
                  $error("kind: expected %0d, got %0d", m.kind, rsp_kind); fail_count++;
               end
               if (rsp_out_dest != m.dest) begin
                  $error("out_dest: expected %0h, got %0h", m.dest, rsp_out_dest);
                  fail_count++;
               end
               if (rsp_out_group != m.group) begin
                  $error("out_group: expected %0d, got %0d", m.group, rsp_out_group);
                  fail_count++;
               end
               if (rsp_out_chan != m.chan) begin
                  $error("out_chan: expected %0d, got %0d", m.chan, rsp_out_chan);
                  fail_count++;
               end
               if (rsp_out_note != m.note) begin
                  $error("out_note: expected %0d, got %0d", m.note, rsp_out_note);
                  fail_count++;
               end
               if (rsp_out_source_track != m.source) begin
                  $error("out_source_track: expected %0h, got %0h", m.source,
                         rsp_out_source_track);
                  fail_count++;
               end
               if (rsp_out_frame != m.frame) begin
                  $error("out_frame: expected %0h, got %0h", m.frame, rsp_out_frame);
                  fail_count++;
               end
               if (rsp_notes_held != m.held) begin
                  $error("notes_held: expected %0d, got %0d", m.held, rsp_notes_held);
                  fail_count++;
               end
               if (rsp_overflow_total != m.dropped) begin
                  $error("overflow_total: expected %0d, got %0d", m.dropped,
                         rsp_overflow_total);
                  fail_count++;
               end
               if (rsp_last != m.last) begin
                  $error("last: expected %0d, got %0d", m.last, rsp_last); fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            apply_request(req_op, req_group, req_chan, req_note_number, req_dest,
                          req_source_track, req_is_from_clip, req_clip, req_frame);
      end
   end

endmodule

@@ tb/tb_active_note_tracker.sv @@
`timescale 1ns / 1ps

// Top of the note tracker bench. It makes the requests, drives the receiver's
// ready and gives the verdict; prediction and comparison live in the checker.
module tb_active_note_tracker;
   import ant_pkg::*;

   // Op codes that the block does not define; they should only yield a done result.
   localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_STALL = 600;

   typedef struct {
      logic [2:0]  op;
      logic [3:0]  group;
      logic [3:0]  chan;
      logic [6:0]  note;
      logic [31:0] dest;
      logic [31:0] source;
      logic        clip_flag;
      logic [31:0] clip;
      logic [47:0] frame;
   } note_req_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_op = '0;
   logic [3:0]  req_group = '0;
   logic [3:0]  req_chan = '0;
   logic [6:0]  req_note_number = '0;
   logic [31:0] req_dest = '0;
   logic [31:0] req_source_track = '0;
   logic        req_is_from_clip = 1'b0;
   logic [31:0] req_clip = '0;
   logic [47:0] req_frame = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_kind;
   logic [31:0] rsp_out_dest;
   logic [3:0]  rsp_out_group;
   logic [3:0]  rsp_out_chan;
   logic [6:0]  rsp_out_note;
   logic [31:0] rsp_out_source_track;
   logic [47:0] rsp_out_frame;
   logic [4:0]  rsp_notes_held;
   logic [15:0] rsp_overflow_total;
   logic        rsp_last;

   int fail_count;
   int pending;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit stall_start = 1'b0;
   bit stall_taken = 1'b0;

   // Note-ons that were sent recently, so that note-offs and releases can
   // aim at notes which are likely to be sounding.
   note_req_type sounding[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   active_note_tracker uut (.*);

   active_note_checker note_check (.*);

   // Receiver. A single long hold-off is counted here once the stimulus asks
   // for it; the sender keeps offering requests meanwhile, so the output
   // register fills and the block stops taking requests.
   always @(posedge clock) begin
      if (stall_start && !stall_taken) begin
         stall_taken <= 1'b1;
         stall_left <= LONG_STALL;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("active_note_tracker test failed");
         $finish;
      end
   end

   function automatic note_req_type make_request(logic [2:0] op, logic [3:0] g,
                                                 logic [3:0] c, logic [6:0] n,
                                                 logic [31:0] d, logic [31:0] s,
                                                 logic fc, logic [31:0] cl,
                                                 logic [47:0] f);
      note_req_type r;
      r.op = op;
      r.group = g;
      r.chan = c;
      r.note = n;
      r.dest = d;
      r.source = s;
      r.clip_flag = fc;
      r.clip = cl;
      r.frame = f;
      return r;
   endfunction

   // Destinations and clips come mostly from a tiny pool so that releases hit.
   function automatic logic [31:0] pick_id();
      case ($urandom_range(0, 7))
         0: return 32'h0;
         1: return 32'hFFFF_FFFF;
         7: return $urandom;
         default: return $urandom_range(1, 3);
      endcase
   endfunction

   function automatic note_req_type random_request();
      note_req_type r;
      logic [63:0] wide;
      int pick;
      int h;
      pick = $urandom_range(0, 99);
      wide = {$urandom, $urandom};
      r.group = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 2));
      r.chan = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 1));
      r.note = 7'($urandom);
      r.dest = pick_id();
      r.source = $urandom;
      r.clip_flag = 1'($urandom);
      r.clip = pick_id();
      r.frame = wide[47:0];
      if (pick < 45) begin
         r.op = OP_NOTE_ON;
         sounding.push_back(r);
         if (sounding.size() > 32) void'(sounding.pop_front());
      end else if (pick < 72) begin
         r.op = OP_NOTE_OFF;
         if (sounding.size() > 0) begin
            h = $urandom_range(0, sounding.size() - 1);
            r = sounding[h];
            r.op = OP_NOTE_OFF;
            r.frame = wide[47:0];
            // Now and then spoil the source so only the looser match applies.
            if ($urandom_range(0, 2) == 0) r.source = $urandom;
            sounding.delete(h);
         end
      end else if (pick < 80) begin
         r.op = OP_REL_CLIP;
         if (sounding.size() > 0)
            r.clip = sounding[$urandom_range(0, sounding.size() - 1)].clip;
      end else if (pick < 88) begin
         r.op = OP_REL_DEST;
         if (sounding.size() > 0)
            r.dest = sounding[$urandom_range(0, sounding.size() - 1)].dest;
      end else if (pick < 93) begin
         r.op = OP_ALL_OFF;
         sounding.delete();
      end else if (pick < 97) begin
         r.op = OP_NOTE_OFF;
      end else begin
         r.op = OP_UNUSED_FIRST + 3'($urandom_range(0, 2));
      end
      return r;
   endfunction

   // Offers one request and returns at the edge on which it is taken.
   task automatic send_request(input note_req_type r);
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_op <= r.op;
      req_group <= r.group;
      req_chan <= r.chan;
      req_note_number <= r.note;
      req_dest <= r.dest;
      req_source_track <= r.source;
      req_is_from_clip <= r.clip_flag;
      req_clip <= r.clip;
      req_frame <= r.frame;
      req_valid <= 1'b1;
      // Ready only moves on rising edges, so the value at the falling edge is
      // the one that the next rising edge sees.
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   initial begin
      note_req_type r;
      int sender_pct[3];
      int receiver_pct[3];
      sender_pct = '{35, 55, 0};
      receiver_pct = '{55, 35, 0};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. All-off on an empty table first.
      send_request(make_request(OP_ALL_OFF, '0, '0, '0, '0, '0, 1'b0, '0, '0));
      // Fill the table: the first entry has every field at its maximum, the
      // second every field at zero, and the rest share groups and channels so
      // that the channel resets must be merged.
      send_request(make_request(OP_NOTE_ON, 4'hF, 4'hF, 7'h7F, 32'hFFFF_FFFF,
                                32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));
      send_request(make_request(OP_NOTE_ON, '0, '0, '0, '0, '0, 1'b0, '0, '0));
      for (int i = 2; i < MAX_NOTES_DEF; i++)
         send_request(make_request(OP_NOTE_ON, 4'(i % 3), 4'(i % 2), 7'(i),
                                   (i % 2) ? 32'hFFFF_FFFF : 32'h0, 32'(i), 1'(i % 2),
                                   (i % 2) ? 32'hFFFF_FFFF : 32'h0, 48'(i)));
      // One more note-on while the table is full is dropped.
      send_request(make_request(OP_NOTE_ON, 4'h1, 4'h2, 7'h3, 32'h4, 32'h5, 1'b0,
                                32'h6, 48'h7));
      // Note-off that matches exactly, one that only matches loosely, one
      // that matches nothing.
      send_request(make_request(OP_NOTE_OFF, '0, '0, '0, '0, '0, 1'b0, '0, 48'h10));
      send_request(make_request(OP_NOTE_OFF, 4'hF, 4'hF, 7'h7F, 32'hFFFF_FFFF, 32'h1,
                                1'b0, '0, 48'h11));
      send_request(make_request(OP_NOTE_OFF, 4'h9, 4'h9, 7'h9, 32'h9, 32'h9, 1'b1,
                                32'h9, 48'h12));
      send_request(make_request(OP_REL_CLIP, '0, '0, '0, '0, '0, 1'b0, 32'hFFFF_FFFF,
                                48'h13));
      send_request(make_request(OP_REL_DEST, '0, '0, '0, '0, '0, 1'b0, '0, 48'h14));
      send_request(make_request(OP_ALL_OFF, '0, '0, '0, '0, '0, 1'b0, '0, 48'h15));
      send_request(make_request(OP_UNUSED_FIRST, '0, '0, '0, '0, '0, 1'b0, '0, 48'h16));
      send_request(make_request(OP_UNUSED_FIRST + 3'd2, 4'hF, 4'hF, 7'h7F,
                                32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF,
                                48'hFFFF_FFFF_FFFF));

      // Random part in three idling phases.
      for (int p = 0; p < 3; p++) begin
         tx_idle_pct <= sender_pct[p];
         rx_idle_pct <= receiver_pct[p];
         for (int i = 0; i < 145; i++) begin
            if (p == 0 && i == 40) stall_start <= 1'b1;
            r = random_request();
            send_request(r);
         end
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0) begin
         $display("active_note_tracker test passed");
      end else begin
         $display("active_note_tracker test failed");
      end
      $finish;
   end

endmodule
